### src/positional_list_engine_defines.svh
// Assertion macros shared by the positional list engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Implication checked in the next cycle, ignored while in reset.
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ple: next-cycle check failed");

// Same-cycle implication, ignored while in reset.
`define PLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ple: same-cycle check failed");

`endif

### src/ple_pkg.sv
// Package for the positional list engine: sizes, opcodes, control structs
// and word conversion helpers. No dependencies.
package ple_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int OP_W       = 4;
  localparam int POS_W      = 5;
  localparam int ITEM_W     = 32;
  localparam int LEN_W      = 5;
  // position and count compared at a common width
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST  = 4'd0,
    OP_INS_LAST   = 4'd1,
    OP_INS_AT     = 4'd2,
    OP_READ_AT    = 4'd3,
    OP_REM_AT     = 4'd4,
    OP_REM_FIRST  = 4'd5,
    OP_REM_LAST   = 4'd6,
    OP_READ_FIRST = 4'd7,
    OP_READ_LAST  = 4'd8,
    OP_CLEAR      = 4'd9
  } op_t;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] idx;
    word_t            wdata;
  } shift_ctrl_t;

  typedef struct packed {
    logic             ok;
    logic             rd;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] cnt_next;
  } dec_t;

  function automatic word_t to_word(input logic [ITEM_W-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [ITEM_W-1:0] to_item(input word_t x);
    logic [63:0] w;
    w = 64'(x);
    return w[ITEM_W-1:0];
  endfunction

endpackage

### src/ple_cell.sv
// One list cell: holds one entry and shifts towards either neighbour.
// Depends on ple_pkg.
module ple_cell (
  input  logic                      clk,
  input  ple_pkg::shift_ctrl_t      ctrl,
  input  logic [ple_pkg::IDX_W-1:0] cell_idx,
  input  ple_pkg::word_t            prev_data,
  input  ple_pkg::word_t            next_data,
  output ple_pkg::word_t            data
);
  import ple_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (cell_idx == ctrl.idx) begin
        data <= ctrl.wdata;
      end else if (cell_idx > ctrl.idx) begin
        data <= prev_data;
      end
    end else if (ctrl.rem && (cell_idx >= ctrl.idx)) begin
      // entries past the end pick up junk; never read
      data <= next_data;
    end
  end

endmodule

### src/ple_decode.sv
// Request decode: checks bounds against the entry count and builds the
// shift command and result control. Depends on ple_pkg.
module ple_decode (
  input  logic [ple_pkg::OP_W-1:0]   opcode,
  input  logic [ple_pkg::POS_W-1:0]  position,
  input  logic [ple_pkg::ITEM_W-1:0] item_data,
  input  logic [ple_pkg::CNT_W-1:0]  count,
  output ple_pkg::shift_ctrl_t       ctrl,
  output ple_pkg::dec_t              dec
);
  import ple_pkg::*;

  op_t              op;
  logic             full;
  logic             empty;
  logic             pos_ok;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] count_c;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] end_idx;

  assign op       = op_t'(opcode);
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_c    = CMP_W'(position);
  assign count_c  = CMP_W'(count);
  assign pos_ok   = (pos_c != '0) && (pos_c <= count_c);
  assign pos_idx  = IDX_W'(pos_c - CMP_W'(1));
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign end_idx  = IDX_W'(count);

  always_comb begin
    ctrl          = '0;
    ctrl.wdata    = to_word(item_data);
    dec           = '0;
    dec.cnt_next  = count;
    unique case (op)
      OP_INS_FIRST: begin
        if (!full) begin
          ctrl.ins = 1'b1;
          dec.ok   = 1'b1;
        end
      end
      OP_INS_LAST: begin
        if (!full) begin
          ctrl.ins = 1'b1;
          ctrl.idx = end_idx;
          dec.ok   = 1'b1;
        end
      end
      OP_INS_AT: begin
        // cannot append: position must name an existing entry
        if (!full && pos_ok) begin
          ctrl.ins = 1'b1;
          ctrl.idx = pos_idx;
          dec.ok   = 1'b1;
        end
      end
      OP_READ_AT: begin
        if (pos_ok) begin
          dec.ok     = 1'b1;
          dec.rd     = 1'b1;
          dec.rd_idx = pos_idx;
        end
      end
      OP_REM_AT: begin
        if (pos_ok) begin
          ctrl.rem   = 1'b1;
          ctrl.idx   = pos_idx;
          dec.ok     = 1'b1;
          dec.rd     = 1'b1;
          dec.rd_idx = pos_idx;
        end
      end
      OP_REM_FIRST: begin
        if (!empty) begin
          ctrl.rem = 1'b1;
          dec.ok   = 1'b1;
          dec.rd   = 1'b1;
        end
      end
      OP_REM_LAST: begin
        if (!empty) begin
          ctrl.rem   = 1'b1;
          ctrl.idx   = last_idx;
          dec.ok     = 1'b1;
          dec.rd     = 1'b1;
          dec.rd_idx = last_idx;
        end
      end
      OP_READ_FIRST: begin
        if (!empty) begin
          dec.ok = 1'b1;
          dec.rd = 1'b1;
        end
      end
      OP_READ_LAST: begin
        if (!empty) begin
          dec.ok     = 1'b1;
          dec.rd     = 1'b1;
          dec.rd_idx = last_idx;
        end
      end
      OP_CLEAR: begin
        if (!empty) begin
          dec.ok       = 1'b1;
          dec.cnt_next = '0;
        end
      end
      default: begin
      end
    endcase
    if (ctrl.ins) begin
      dec.cnt_next = count + CNT_W'(1);
    end else if (ctrl.rem) begin
      dec.cnt_next = count - CNT_W'(1);
    end
  end

endmodule

### src/positional_list_engine.sv
// Positional list engine top level: entry count, row of list cells and
// registered result. Depends on ple_pkg, ple_decode, ple_cell and the defines.
//
//   channel  | handshake            | fields
//   ---------+----------------------+----------------------------------------
//   request  | start, busy          | opcode, position, item_data
//   result   | done (one-cycle)     | status, read_data, length, is_empty
//
// One item per clock: an item taken at one edge has its result on the ports,
// with done high, for the cycle after that edge. Every cell shifts in the
// accept cycle, so inserts and removes anywhere finish at the accepting edge.
// busy is never raised. rst clears the entry count and done; cell contents
// stay undefined until written. Results cannot be stalled.
`include "positional_list_engine_defines.svh"

module positional_list_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ple_pkg::OP_W-1:0]  opcode,
  input  logic [ple_pkg::POS_W-1:0] position,
  input  logic [ple_pkg::ITEM_W-1:0] item_data,
  output logic                      done,
  output logic                      status,
  output logic [ple_pkg::ITEM_W-1:0] read_data,
  output logic [ple_pkg::LEN_W-1:0] length,
  output logic                      is_empty
);
  import ple_pkg::*;

  logic             accept;
  logic [CNT_W-1:0] count;
  shift_ctrl_t      ctrl;
  shift_ctrl_t      cell_ctrl;
  dec_t             dec;
  word_t            cell_data [CAPACITY];
  word_t            rd_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ple_decode u_decode (
    .opcode    (opcode),
    .position  (position),
    .item_data (item_data),
    .count     (count),
    .ctrl      (ctrl),
    .dec       (dec)
  );

  // shifts only happen on an accepted item
  always_comb begin
    cell_ctrl     = ctrl;
    cell_ctrl.ins = ctrl.ins && accept;
    cell_ctrl.rem = ctrl.rem && accept;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t prev_w;
    word_t next_w;
    if (i == 0) begin : g_head
      assign prev_w = cell_data[0];
    end else begin : g_body
      assign prev_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_w = cell_data[CAPACITY-1];
    end else begin : g_inner
      assign next_w = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .cell_idx  (IDX_W'(i)),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[i])
    );
  end

  // sampled before the shift lands
  assign rd_word = cell_data[dec.rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= dec.cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= !dec.ok;
      read_data <= (dec.ok && dec.rd) ? to_item(rd_word) : '0;
      length    <= LEN_W'(dec.cnt_next);
      is_empty  <= (dec.cnt_next == '0);
    end
  end

  `PLE_ASSERT_NEXT(a_done_follows_accept, accept, done)
  `PLE_ASSERT_NEXT(a_no_spurious_done, !accept, !done)
  `PLE_ASSERT_NOW(a_count_in_range, 1'b1, count <= CNT_W'(CAPACITY))
  `PLE_ASSERT_NOW(a_empty_matches_count, done, is_empty == (count == '0))
  `PLE_ASSERT_NOW(a_fail_reads_zero, done && status, read_data == '0)
  `PLE_ASSERT_NEXT(a_insert_grows, accept && ctrl.ins, count == CNT_W'($past(count) + 1'b1))

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for positional_list_engine: directed corner cases, then phased
// random traffic with random request gaps, checked against a behavioural list.
// Depends on ple_pkg and the positional_list_engine RTL.
module tb_top;
  import ple_pkg::*;

  localparam int MAX_GAP     = 17;
  localparam int STALL_LIMIT = 500;
  localparam int PHASES      = 12;
  localparam int PHASE_LEN   = 102;
  localparam logic [OP_W-1:0] FIRST_SPARE_OP = 4'd10;
  localparam logic [OP_W-1:0] LAST_SPARE_OP  = 4'd15;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [ITEM_W-1:0] data;
    int                gap;
    bit                drain;
  } list_request_t;

  typedef struct packed {
    logic              status;
    logic [ITEM_W-1:0] read_data;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [OP_W-1:0]   opcode = '0;
  logic [POS_W-1:0]  position = '0;
  logic [ITEM_W-1:0] item_data = '0;
  logic              busy;
  logic              done;
  logic              status;
  logic [ITEM_W-1:0] read_data;
  logic [LEN_W-1:0]  length;
  logic              is_empty;

  positional_list_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .position  (position),
    .item_data (item_data),
    .done      (done),
    .status    (status),
    .read_data (read_data),
    .length    (length),
    .is_empty  (is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioural copy of the list
  word_t         shadow_cells [CAPACITY];
  int            shadow_count = 0;

  list_request_t pending_requests [$];
  list_result_t  expected_results [$];
  list_request_t cur_request;
  logic          taken = 1'b0;
  int            gap_left = 0;
  int            idle_cycles = 0;
  int            mismatches = 0;
  int            requests_taken = 0;
  int            results_checked = 0;
  int            rejected_seen = 0;
  int            full_seen = 0;
  int            empty_seen = 0;

  function automatic void shadow_insert(int idx, logic [ITEM_W-1:0] data);
    for (int k = shadow_count; k > idx; k--) shadow_cells[k] = shadow_cells[k-1];
    shadow_cells[idx] = word_t'(data);
    shadow_count++;
  endfunction

  function automatic word_t shadow_remove(int idx);
    word_t v;
    v = shadow_cells[idx];
    for (int k = idx; k + 1 < shadow_count; k++) shadow_cells[k] = shadow_cells[k+1];
    shadow_count--;
    return v;
  endfunction

  function automatic list_result_t predict_list_op(logic [OP_W-1:0] op,
                                                   logic [POS_W-1:0] pos,
                                                   logic [ITEM_W-1:0] data);
    list_result_t res;
    logic         ok;
    word_t        rd;
    logic         full;
    logic         pos_ok;
    ok     = 1'b0;
    rd     = '0;
    full   = shadow_count >= CAPACITY;
    pos_ok = pos >= 1 && pos <= shadow_count;
    case (op)
      OP_INS_FIRST:  if (!full) begin shadow_insert(0, data); ok = 1'b1; end
      OP_INS_LAST:   if (!full) begin shadow_insert(shadow_count, data); ok = 1'b1; end
      OP_INS_AT:     if (!full && pos_ok) begin shadow_insert(pos - 1, data); ok = 1'b1; end
      OP_READ_AT:    if (pos_ok) begin rd = shadow_cells[pos - 1]; ok = 1'b1; end
      OP_REM_AT:     if (pos_ok) begin rd = shadow_remove(pos - 1); ok = 1'b1; end
      OP_REM_FIRST:  if (shadow_count > 0) begin rd = shadow_remove(0); ok = 1'b1; end
      OP_REM_LAST:   if (shadow_count > 0) begin
        rd = shadow_remove(shadow_count - 1);
        ok = 1'b1;
      end
      OP_READ_FIRST: if (shadow_count > 0) begin rd = shadow_cells[0]; ok = 1'b1; end
      OP_READ_LAST:  if (shadow_count > 0) begin
        rd = shadow_cells[shadow_count - 1];
        ok = 1'b1;
      end
      OP_CLEAR:      if (shadow_count > 0) begin shadow_count = 0; ok = 1'b1; end
      default: ;
    endcase
    res.status    = !ok;
    res.read_data = ok ? ITEM_W'(rd) : '0;
    res.length    = LEN_W'(shadow_count);
    res.is_empty  = shadow_count == 0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [ITEM_W-1:0] want,
                                 logic [ITEM_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Monitor: results are registered at the request edge and seen at the next
  // edge, so check the result before queueing the prediction for this edge.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, read_data);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) report_mismatch("status", want.status, status);
          if (read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, read_data);
          if (length !== want.length) report_mismatch("length", want.length, length);
          if (is_empty !== want.is_empty)
            report_mismatch("is_empty", want.is_empty, is_empty);
          results_checked++;
          if (want.status) rejected_seen++;
          if (want.length == CAPACITY) full_seen++;
          if (want.is_empty) empty_seen++;
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        expected_results.push_back(predict_list_op(opcode, position, item_data));
        requests_taken++;
      end
      if (done || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: %0d cycles without progress, %0d results outstanding",
                 idle_cycles, expected_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Driver: holds an item until taken, then waits out that item's gap.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || taken) begin
      if (start) gap_left = cur_request.gap;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].drain && expected_results.size() != 0)) begin
        start <= 1'b0;
      end else begin
        cur_request = pending_requests.pop_front();
        start     <= 1'b1;
        opcode    <= cur_request.op;
        position  <= cur_request.pos;
        item_data <= cur_request.data;
      end
    end
  end

  task automatic queue_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [ITEM_W-1:0] data, int gap, bit drain);
    list_request_t req;
    req.op    = op;
    req.pos   = pos;
    req.data  = data;
    req.gap   = gap;
    req.drain = drain;
    pending_requests.push_back(req);
  endtask

  function automatic logic [OP_W-1:0] pick_op(traffic_mix_t mix);
    int r;
    int ins_lim;
    int read_lim;
    int rem_lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin ins_lim = 60; read_lim = 82; rem_lim = 96; end
      MIX_SHRINK: begin ins_lim = 15; read_lim = 35; rem_lim = 93; end
      default:    begin ins_lim = 35; read_lim = 60; rem_lim = 93; end
    endcase
    if (r < ins_lim) begin
      case ($urandom_range(0, 2))
        0:       return OP_INS_FIRST;
        1:       return OP_INS_LAST;
        default: return OP_INS_AT;
      endcase
    end else if (r < read_lim) begin
      case ($urandom_range(0, 2))
        0:       return OP_READ_AT;
        1:       return OP_READ_FIRST;
        default: return OP_READ_LAST;
      endcase
    end else if (r < rem_lim) begin
      case ($urandom_range(0, 2))
        0:       return OP_REM_AT;
        1:       return OP_REM_FIRST;
        default: return OP_REM_LAST;
      endcase
    end else if (r < 98) begin
      return OP_CLEAR;
    end
    return OP_W'($urandom_range(FIRST_SPARE_OP, LAST_SPARE_OP));
  endfunction

  initial begin
    traffic_mix_t      mix;
    int                gap_max;
    logic [POS_W-1:0]  pos;
    logic [ITEM_W-1:0] data;

    // empty list: everything that needs an entry must fail
    queue_request(OP_READ_FIRST, 0, 0, 0, 0);
    queue_request(OP_READ_LAST, 0, 0, 1, 0);
    queue_request(OP_REM_FIRST, 0, 0, 0, 0);
    queue_request(OP_REM_LAST, 0, 0, 0, 0);
    queue_request(OP_CLEAR, 0, 0, 2, 0);
    queue_request(OP_INS_AT, 1, 32'h1234_5678, 0, 0);
    queue_request(OP_READ_AT, 1, 0, 0, 0);
    queue_request(OP_REM_AT, 0, 0, 0, 0);
    // build [0, a5, 5a, ff] and probe the position bounds
    queue_request(OP_INS_FIRST, 0, 32'h0000_0000, 0, 0);
    queue_request(OP_INS_LAST, 31, 32'hFFFF_FFFF, 0, 0);
    queue_request(OP_INS_AT, 2, 32'hA5A5_A5A5, 1, 0);
    queue_request(OP_INS_AT, 3, 32'h5A5A_5A5A, 0, 0);
    queue_request(OP_INS_AT, 5, 32'hDEAD_BEEF, 0, 0);
    queue_request(OP_INS_AT, 0, 32'hDEAD_BEEF, 0, 0);
    queue_request(OP_READ_AT, 0, 0, 0, 0);
    queue_request(OP_READ_AT, 4, 0, 0, 0);
    queue_request(OP_READ_AT, 31, 0, 3, 0);
    queue_request(OP_REM_AT, 2, 0, 0, 0);
    queue_request(OP_READ_FIRST, 0, 0, 0, 0);
    queue_request(OP_READ_LAST, 0, 0, 0, 0);
    queue_request(OP_REM_FIRST, 0, 0, 0, 0);
    queue_request(OP_REM_LAST, 0, 0, 0, 0);
    queue_request(FIRST_SPARE_OP, 1, 32'hFFFF_FFFF, 0, 0);
    queue_request(LAST_SPARE_OP, 31, 32'hFFFF_FFFF, 0, 0);
    queue_request(OP_CLEAR, 0, 0, 0, 0);

    // random phases; grow phases run into the full list, shrink ones into empty
    for (int p = 0; p < PHASES; p++) begin
      mix = traffic_mix_t'(p % 3);
      case (p % 4)
        1:       gap_max = 0;
        2:       gap_max = 3;
        default: gap_max = MAX_GAP;
      endcase
      for (int i = 0; i < PHASE_LEN; i++) begin
        if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 31));
        else pos = POS_W'($urandom_range(1, CAPACITY));
        case ($urandom_range(0, 19))
          0:       data = '0;
          1:       data = '1;
          default: data = $urandom();
        endcase
        queue_request(pick_op(mix), pos, data, $urandom_range(0, gap_max), i == 0);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Ran %0d requests, %0d results checked: %0d rejected,", requests_taken,
             results_checked, rejected_seen);
    $display("%0d left the list full and %0d left it empty.", full_seen, empty_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
